@@ rtl/prrts_pkg.sv @@
// Shared types, codes and defaults for the priority round-robin task scheduler.
package prrts_pkg;

  localparam int TASK_SLOTS_DEF = 16;
  localparam int PRIORITY_LEVELS_DEF = 16;

  localparam logic [2:0] ST_INVALID = 3'd0;
  localparam logic [2:0] ST_READY   = 3'd2;
  localparam logic [2:0] ST_DELAYED = 3'd3;

  localparam logic REG_PRIORITY_MODE = 1'b0;
  localparam logic REG_PREEMPTION    = 1'b1;

  typedef enum logic [1:0] {
    MODE_TICK     = 2'd0,
    MODE_SCHEDULE = 2'd1,
    MODE_WRITE    = 2'd2,
    MODE_SLEEP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } ctrl_state_e;

  typedef struct packed {
    mode_e       mode;
    logic [3:0]  task_index;
    logic [2:0]  new_state;
    logic [3:0]  new_priority;
    logic [31:0] sleep_ticks;
  } item_t;

  typedef struct packed {
    logic [3:0] selected_task;
    logic       none_ready;
    logic       switch_request;
  } result_t;

endpackage

@@ rtl/priority_round_robin_task_scheduler.sv @@
// Top level of the priority round-robin task scheduler with its register port.
//
//   Channel   Direction  Handshake              Payload
//   in        receive    in_valid_i/in_stall_o  mode, task_index, new_state, new_priority,
//                                               sleep_ticks
//   out       send       out_valid_o/out_stall_i selected_task, none_ready, switch_request
//   config    receive    APB psel/penable       priority_mode at 0x0, preemption_enable at 0x4
//
// Write and sleep items go from idle straight to the finish state; tick and schedule items make
// one pass of the table memories through the shared update and compare unit.
// Reset clears per-entry valid bits at once, so no clearing pass is needed.
// A finished result waits in the sequencer while the output register is full and stalled.
module priority_round_robin_task_scheduler #(
  parameter int TASK_SLOTS = prrts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = prrts_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  mode_i,
  input  logic [3:0]  task_index_i,
  input  logic [2:0]  new_state_i,
  input  logic [3:0]  new_priority_i,
  input  logic [31:0] sleep_ticks_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [3:0]  selected_task_o,
  output logic        none_ready_o,
  output logic        switch_request_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import prrts_pkg::*;

  logic priority_mode_q, preempt_q;
  logic cfg_write;
  logic ctrl_idle, ctrl_done, out_free, in_accept;
  item_t item;
  result_t result;
  logic out_valid_q;
  result_t out_q;

  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      priority_mode_q <= 1'b1;
      preempt_q <= 1'b0;
    end else if (cfg_write) begin
      unique case (paddr[2])
        REG_PRIORITY_MODE: priority_mode_q <= pwdata[0];
        REG_PREEMPTION:    preempt_q <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_PRIORITY_MODE: prdata = {31'd0, priority_mode_q};
      REG_PREEMPTION:    prdata = {31'd0, preempt_q};
      default:           prdata = '0;
    endcase
  end

  assign in_stall_o = !ctrl_idle;
  assign in_accept = in_valid_i && ctrl_idle;
  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    item.mode = mode_e'(mode_i);
    item.task_index = task_index_i;
    item.new_state = new_state_i;
    item.new_priority = new_priority_i;
    item.sleep_ticks = sleep_ticks_i;
  end

  prrts_ctrl #(
    .TASK_SLOTS      (TASK_SLOTS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_ctrl (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start_i         (in_accept),
    .item_i          (item),
    .priority_mode_i (priority_mode_q),
    .preempt_i       (preempt_q),
    .out_free_i      (out_free),
    .idle_o          (ctrl_idle),
    .done_o          (ctrl_done),
    .result_o        (result)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl_done) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_done) begin
      out_q <= result;
    end
  end

  assign out_valid_o = out_valid_q;
  assign selected_task_o = out_q.selected_task;
  assign none_ready_o = out_q.none_ready;
  assign switch_request_o = out_q.switch_request;

endmodule

@@ rtl/prrts_ram.sv @@
// Simple dual-port memory with one write port and one registered read port.
module prrts_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = prrts_pkg::TASK_SLOTS_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/prrts_ctrl.sv @@
// Sequencer that walks the task table through one shared compare and update unit.
module prrts_ctrl #(
  parameter int TASK_SLOTS = prrts_pkg::TASK_SLOTS_DEF,
  parameter int PRIORITY_LEVELS = prrts_pkg::PRIORITY_LEVELS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  prrts_pkg::item_t   item_i,
  input  logic               priority_mode_i,
  input  logic               preempt_i,
  input  logic               out_free_i,
  output logic               idle_o,
  output logic               done_o,
  output prrts_pkg::result_t result_o
);
  import prrts_pkg::*;

  localparam int IDX_W = $clog2(TASK_SLOTS);
  localparam int CNT_W = $clog2(TASK_SLOTS + 1);
  localparam int LVL_W = $clog2(PRIORITY_LEVELS);
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TASK_SLOTS - 1);
  localparam logic [CNT_W-1:0] CNT_END = CNT_W'(TASK_SLOTS);
  localparam logic [LVL_W-1:0] LVL_MAX = LVL_W'(PRIORITY_LEVELS - 1);

  ctrl_state_e state_q, state_d;
  item_t item_q;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [IDX_W-1:0] ptr_q, ptr_d;
  logic [IDX_W-1:0] rd_addr_q;
  logic rd_vld_q, rd_vld_d;
  logic stat_hit_q, wake_hit_q;
  logic found_q, found_d;
  logic [LVL_W-1:0] best_q, best_d;
  logic [IDX_W-1:0] best_idx_q, best_idx_d;
  logic [IDX_W-1:0] last_pick_q, last_pick_d;
  logic [TASK_SLOTS-1:0] stat_vld_q, stat_vld_d;
  logic [TASK_SLOTS-1:0] wake_vld_q, wake_vld_d;

  logic stat_we, lvl_we, wake_we;
  logic [IDX_W-1:0] waddr;
  logic [2:0] stat_wdata, stat_rdata, cur_stat;
  logic [LVL_W-1:0] lvl_wdata, lvl_rdata;
  logic [31:0] wake_wdata, wake_rdata, cur_wake;
  logic [IDX_W-1:0] in_addr;
  logic idx_ok;
  logic [LVL_W-1:0] sat_lvl;

  function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] s);
    return (s == LAST_IDX) ? '0 : s + 1'b1;
  endfunction

  prrts_ram #(.WIDTH(3), .DEPTH(TASK_SLOTS)) u_stat_ram (
    .clk_i   (clk_i),
    .we_i    (stat_we),
    .waddr_i (waddr),
    .wdata_i (stat_wdata),
    .raddr_i (ptr_q),
    .rdata_o (stat_rdata)
  );

  prrts_ram #(.WIDTH(LVL_W), .DEPTH(TASK_SLOTS)) u_lvl_ram (
    .clk_i   (clk_i),
    .we_i    (lvl_we),
    .waddr_i (waddr),
    .wdata_i (lvl_wdata),
    .raddr_i (ptr_q),
    .rdata_o (lvl_rdata)
  );

  prrts_ram #(.WIDTH(32), .DEPTH(TASK_SLOTS)) u_wake_ram (
    .clk_i   (clk_i),
    .we_i    (wake_we),
    .waddr_i (waddr),
    .wdata_i (wake_wdata),
    .raddr_i (ptr_q),
    .rdata_o (wake_rdata)
  );

  assign in_addr = IDX_W'(item_i.task_index);
  assign idx_ok = (32'(item_i.task_index) < 32'(TASK_SLOTS));
  assign sat_lvl = (9'(item_i.new_priority) >= 9'(PRIORITY_LEVELS)) ? LVL_MAX
                                                                    : LVL_W'(item_i.new_priority);
  assign cur_stat = stat_hit_q ? stat_rdata : ST_INVALID;
  assign cur_wake = wake_hit_q ? wake_rdata : '0;
  assign idle_o = (state_q == S_IDLE);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    ptr_d = ptr_q;
    rd_vld_d = 1'b0;
    found_d = found_q;
    best_d = best_q;
    best_idx_d = best_idx_q;
    last_pick_d = last_pick_q;
    stat_vld_d = stat_vld_q;
    wake_vld_d = wake_vld_q;
    stat_we = 1'b0;
    lvl_we = 1'b0;
    wake_we = 1'b0;
    waddr = rd_addr_q;
    stat_wdata = ST_READY;
    lvl_wdata = sat_lvl;
    wake_wdata = '0;
    done_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          cnt_d = '0;
          found_d = 1'b0;
          best_d = '0;
          best_idx_d = '0;
          state_d = S_FINISH;
          waddr = in_addr;
          unique case (item_i.mode)
            MODE_TICK: begin
              ptr_d = '0;
              state_d = S_SCAN;
            end
            MODE_SCHEDULE: begin
              ptr_d = next_slot(last_pick_q);
              state_d = S_SCAN;
            end
            MODE_WRITE: begin
              if (idx_ok) begin
                stat_we = 1'b1;
                lvl_we = 1'b1;
                stat_wdata = item_i.new_state;
                stat_vld_d[in_addr] = 1'b1;
              end
            end
            MODE_SLEEP: begin
              if (idx_ok) begin
                stat_we = 1'b1;
                wake_we = 1'b1;
                stat_wdata = ST_DELAYED;
                wake_wdata = item_i.sleep_ticks;
                stat_vld_d[in_addr] = 1'b1;
                wake_vld_d[in_addr] = 1'b1;
              end
            end
            default: ;
          endcase
        end
      end
      S_SCAN: begin
        if (cnt_q != CNT_END) begin
          rd_vld_d = 1'b1;
          ptr_d = next_slot(ptr_q);
          cnt_d = cnt_q + 1'b1;
        end else if (!rd_vld_q) begin
          state_d = S_FINISH;
        end
        if (rd_vld_q) begin
          if (item_q.mode == MODE_TICK) begin
            if (cur_stat == ST_DELAYED) begin
              wake_we = 1'b1;
              wake_vld_d[rd_addr_q] = 1'b1;
              if (cur_wake <= 32'd1) begin
                wake_wdata = '0;
                stat_we = 1'b1;
                stat_wdata = ST_READY;
                stat_vld_d[rd_addr_q] = 1'b1;
              end else begin
                wake_wdata = cur_wake - 32'd1;
              end
            end
          end else if (cur_stat == ST_READY) begin
            if (!found_q || (priority_mode_i && (lvl_rdata < best_q))) begin
              found_d = 1'b1;
              best_d = lvl_rdata;
              best_idx_d = rd_addr_q;
            end
          end
        end
      end
      S_FINISH: begin
        if (out_free_i) begin
          done_o = 1'b1;
          state_d = S_IDLE;
          if (item_q.mode == MODE_SCHEDULE && found_q) begin
            last_pick_d = best_idx_q;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    result_o.selected_task = 4'((item_q.mode == MODE_SCHEDULE && found_q) ? best_idx_q
                                                                           : last_pick_q);
    result_o.none_ready = (item_q.mode == MODE_SCHEDULE) && !found_q;
    result_o.switch_request = (item_q.mode == MODE_TICK) && preempt_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q <= '0;
      ptr_q <= '0;
      rd_vld_q <= 1'b0;
      found_q <= 1'b0;
      best_q <= '0;
      best_idx_q <= '0;
      last_pick_q <= LAST_IDX;
      stat_vld_q <= '0;
      wake_vld_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
      ptr_q <= ptr_d;
      rd_vld_q <= rd_vld_d;
      found_q <= found_d;
      best_q <= best_d;
      best_idx_q <= best_idx_d;
      last_pick_q <= last_pick_d;
      stat_vld_q <= stat_vld_d;
      wake_vld_q <= wake_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i && state_q == S_IDLE) begin
      item_q <= item_i;
    end
    rd_addr_q <= ptr_q;
    stat_hit_q <= stat_vld_q[ptr_q];
    wake_hit_q <= wake_vld_q[ptr_q];
  end

endmodule
